// ===== hdl/mbd_pkg.sv =====
// ---------------------------------------------------------------------------
// mbd_pkg
// Shared constants and types for the multi-button debouncer.
// ---------------------------------------------------------------------------
package mbd_pkg;

  localparam int NUM_CHANNELS = 10;
  localparam int TIME_W       = 32;
  localparam int DEB_W        = 16;
  localparam int IDX_W        = 4;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);

  // raw and stable level codes
  localparam logic LEVEL_HIGH = 1'b1;
  localparam logic LEVEL_LOW  = 1'b0;

  // what one lane found for the poll being accepted
  typedef struct packed {
    logic hit;
    logic pressed;
  } lane_res_t;

  // merge stage status seen by the top level
  typedef struct packed {
    logic pend_any;
    logic room;
  } merge_status_t;

endpackage

// ===== hdl/multi_button_debouncer.sv =====
// ---------------------------------------------------------------------------
// multi_button_debouncer
// Timestamp debouncer for a bank of push buttons with per-button events.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one request is one poll with the current
// millisecond time now_ms and the raw levels raw_levels (1 released, 0
// pressed). All button lanes evaluate the poll in the cycle it is accepted.
// Output channel (out_valid/out_ready): one request per stable change, with
// button_index, pressed and last_event; lowest index first, the final one of
// a poll marked. A quiet poll produces nothing.
// The first event of a poll passes through the pending mask and then the
// output register. Events leave one per cycle from the output register
// while the receiver is ready. The next poll is taken in the cycle the last
// pending event moves to the output register, so polls run back to back.
// The user must write debounce_time with debounce_we only while the block
// is idle; the block itself does not enforce this.
// Reset: all buttons released, change times zero, debounce_time = 50.
// A stalled receiver holds the output register; in_ready drops while events
// of the current poll are still waiting.
// ---------------------------------------------------------------------------
module multi_button_debouncer
  import mbd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    debounce_we,
  input  logic [DEB_W-1:0]        debounce_time,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_W-1:0]       now_ms,
  input  logic [NUM_CHANNELS-1:0] raw_levels,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        button_index,
  output logic                    pressed,
  output logic                    last_event
);

  logic [DEB_W-1:0]        debounce;
  logic                    accept;
  lane_res_t               res [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] hit_mask;
  logic [NUM_CHANNELS-1:0] press_mask;
  merge_status_t           status;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= DEBOUNCE_RESET;
    end else if (debounce_we) begin
      debounce <= debounce_time;
    end
  end

  assign in_ready = status.room;
  assign accept   = in_valid && in_ready;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    mbd_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .take          (accept),
      .now_ms        (now_ms),
      .raw           (raw_levels[g]),
      .debounce_time (debounce),
      .res           (res[g])
    );
    assign hit_mask[g]   = res[g].hit;
    assign press_mask[g] = res[g].pressed;
  end

  mbd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .hit_mask     (hit_mask),
    .press_mask   (press_mask),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_index (button_index),
    .pressed      (pressed),
    .last_event   (last_event)
  );

  // a poll with any hit leaves pending events behind
  a_hit_pends: assert property (@(posedge clk) disable iff (rst)
    accept && (hit_mask != '0) |=> status.pend_any)
    else $error("accepted hits not queued");

  // an unmarked event means more of the same poll are still queued
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_event |-> status.pend_any)
    else $error("unmarked event with nothing behind it");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (button_index < IDX_W'(NUM_CHANNELS)))
    else $error("button index out of range");

endmodule

// ===== hdl/mbd_lane.sv =====
// ---------------------------------------------------------------------------
// mbd_lane
// One button channel: tracks the last raw level, the time of the last raw
// change and the stable level, and flags a stable change on each request.
// ---------------------------------------------------------------------------
module mbd_lane
  import mbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              raw,
  input  logic [DEB_W-1:0]  debounce_time,
  output lane_res_t         res
);

  logic              prev_raw;
  logic              stable;
  logic [TIME_W-1:0] change_time;
  logic              changed;
  logic [TIME_W-1:0] elapsed;

  assign changed = (raw != prev_raw);
  assign elapsed = now_ms - change_time;

  // a raw change in this request blocks the event and restarts the change time
  assign res.hit     = !changed && (elapsed > {{(TIME_W-DEB_W){1'b0}}, debounce_time})
                       && (raw != stable);
  assign res.pressed = (raw == LEVEL_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw    <= LEVEL_HIGH;
      stable      <= LEVEL_HIGH;
      change_time <= '0;
    end else if (take) begin
      prev_raw <= raw;
      if (changed) begin
        change_time <= now_ms;
      end
      if (res.hit) begin
        stable <= raw;
      end
    end
  end

endmodule

// ===== hdl/mbd_merge.sv =====
// ---------------------------------------------------------------------------
// mbd_merge
// Collects the lane hits of one request and sends them out one per cycle
// while the receiver is ready, lowest channel first, marking the last one.
// ---------------------------------------------------------------------------
module mbd_merge
  import mbd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [NUM_CHANNELS-1:0] hit_mask,
  input  logic [NUM_CHANNELS-1:0] press_mask,
  output merge_status_t           status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        button_index,
  output logic                    pressed,
  output logic                    last_event
);

  logic [NUM_CHANNELS-1:0] pend;
  logic [NUM_CHANNELS-1:0] pend_after;
  logic [NUM_CHANNELS-1:0] pend_next;
  logic [NUM_CHANNELS-1:0] press_vec;
  logic [NUM_CHANNELS-1:0] low_bit;
  logic [IDX_W-1:0]        pick;
  logic                    take;

  assign take    = (pend != '0) && (!out_valid || out_ready);
  assign low_bit = pend & ~(pend - NUM_CHANNELS'(1));

  always_comb begin
    pick = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick = IDX_W'(i);
      end
    end
  end

  assign pend_after = take ? (pend & (pend - NUM_CHANNELS'(1))) : pend;
  assign pend_next  = load ? hit_mask : pend_after;

  assign status.pend_any = (pend != '0);
  assign status.room     = (pend_after == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      pend <= pend_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      press_vec <= press_mask;
    end
    if (take) begin
      button_index <= pick;
      pressed      <= |(low_bit & press_vec);
      last_event   <= (pend_after == '0);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-button debouncer.
// ---------------------------------------------------------------------------
// Polls are driven on the input channel in random bursts. A tracker inside
// the bench keeps its own stable levels, raw levels and change times, works
// out the button events each accepted poll must give, and checks every event
// taken on the output channel in order. The run covers wrap of the
// millisecond time, the debounce boundary, bounce, all-button changes, and
// several debounce settings including both extremes. The output side stalls
// in changing patterns.
// ---------------------------------------------------------------------------
module tb_top;
  import mbd_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_POLLS   = 35;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             pressed;
    logic             last;
  } btn_event_t;

  class press_tracker;
    logic [NUM_CHANNELS-1:0] stable;
    logic [NUM_CHANNELS-1:0] last_raw;
    logic [TIME_W-1:0]       change_at [NUM_CHANNELS];
    logic [DEB_W-1:0]        hold_ms;
    btn_event_t              due_events [$];
    int                      errors;
    int                      polls;
    int                      events;

    function new();
      stable   = '1;
      last_raw = '1;
      foreach (change_at[i]) change_at[i] = '0;
      hold_ms  = DEBOUNCE_RESET;
      errors   = 0;
      polls    = 0;
      events   = 0;
    endfunction

    function void set_hold(logic [DEB_W-1:0] v);
      hold_ms = v;
    endfunction

    function void take_poll(logic [TIME_W-1:0] t, logic [NUM_CHANNELS-1:0] r);
      btn_event_t        ev;
      logic [TIME_W-1:0] elapsed;
      int                queued_before;
      queued_before = due_events.size();
      polls++;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        if (r[ch] != last_raw[ch]) begin
          change_at[ch] = t;
          last_raw[ch]  = r[ch];
        end
        // wrapped difference, so a time wrap needs no special handling
        elapsed = t - change_at[ch];
        if (elapsed > TIME_W'(hold_ms) && r[ch] != stable[ch]) begin
          stable[ch] = r[ch];
          ev.idx     = IDX_W'(ch);
          ev.pressed = (r[ch] == LEVEL_LOW);
          ev.last    = 1'b0;
          due_events.push_back(ev);
        end
      end
      if (due_events.size() > queued_before) begin
        ev      = due_events.pop_back();
        ev.last = 1'b1;
        due_events.push_back(ev);
      end
    endfunction

    function void match_event(logic [IDX_W-1:0] idx, logic p, logic l);
      btn_event_t want;
      events++;
      if (due_events.size() == 0) begin
        $error("button event with none due: button_index=%0d pressed=%0d", idx, p);
        errors++;
        return;
      end
      want = due_events.pop_front();
      if (idx !== want.idx) begin
        $error("button_index: expected %0d, got %0d", want.idx, idx);
        errors++;
      end
      if (p !== want.pressed) begin
        $error("pressed: expected %0d, got %0d", want.pressed, p);
        errors++;
      end
      if (l !== want.last) begin
        $error("last_event: expected %0d, got %0d", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    debounce_we;
  logic [DEB_W-1:0]        debounce_time;
  logic                    in_valid;
  logic                    in_ready;
  logic [TIME_W-1:0]       now_ms;
  logic [NUM_CHANNELS-1:0] raw_levels;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        button_index;
  logic                    pressed;
  logic                    last_event;

  press_tracker            tracker = new();
  int                      burst_left;
  int                      settings;
  int                      quiet_cycles = 0;
  int                      ready_mode = 0;
  int                      rx_cycle = 0;
  logic [NUM_CHANNELS-1:0] sent_raw;

  multi_button_debouncer u_top (
    .clk           (clk),
    .rst           (rst),
    .debounce_we   (debounce_we),
    .debounce_time (debounce_time),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .raw_levels    (raw_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .button_index  (button_index),
    .pressed       (pressed),
    .last_event    (last_event)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // output side stall pattern, mode changes every so often
  always @(negedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (rx_cycle % 97 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      2: out_ready <= ((rx_cycle % 5) < 2);
      default: out_ready <= ((rx_cycle % 32) >= 20);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.match_event(button_index, pressed, last_event);
      if (in_valid && in_ready) tracker.take_poll(now_ms, raw_levels);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_poll(logic [TIME_W-1:0] t, logic [NUM_CHANNELS-1:0] r);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    now_ms     <= t;
    raw_levels <= r;
    sent_raw   = r;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // quiet polls give no event, so keep clocking on past the last one to settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold(logic [DEB_W-1:0] v);
    @(negedge clk);
    debounce_we   <= 1'b1;
    debounce_time <= v;
    @(negedge clk);
    debounce_we <= 1'b0;
    tracker.set_hold(v);
    settings++;
  endtask

  task automatic run_phase(logic [DEB_W-1:0] hold, int n_polls);
    logic [TIME_W-1:0]       t;
    logic [NUM_CHANNELS-1:0] r;
    logic [NUM_CHANNELS-1:0] m;
    logic [NUM_CHANNELS-1:0] goal;
    int                      h;
    int                      kind;
    int                      count;
    drain();
    write_hold(hold);
    h = hold;
    if ($urandom_range(0, 2) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 2 * h + 20);
    else t = $urandom();
    r = sent_raw;
    count = 0;
    while (count < n_polls) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // bounce on a set of buttons, then settle and hold
        if (kind == 0) m = r ^ (($urandom_range(0, 1) == 0) ? '0 : '1);
        else if (kind < 3) begin
          m = '0;
          m[$urandom_range(0, NUM_CHANNELS - 1)] = 1'b1;
        end else m = NUM_CHANNELS'($urandom_range(1, 1023));
        goal = r ^ m;
        repeat ($urandom_range(0, 3)) begin
          r = r ^ (m & NUM_CHANNELS'($urandom()));
          t += $urandom_range(0, h);
          send_poll(t, r);
          count++;
        end
        r = goal;
        t += $urandom_range(0, h / 2);
        send_poll(t, r);
        if ($urandom_range(0, 3) == 0) begin
          t += h;
          send_poll(t, r);
          t += 1;
        end else t += h + 1 + $urandom_range(0, 3);
        send_poll(t, r);
        count += 2;
      end else if (kind < 9) begin
        t = $urandom();
        r = NUM_CHANNELS'($urandom_range(0, 1023));
        send_poll(t, r);
        count++;
      end else begin
        t += $urandom_range(0, 2 * h + 2);
        send_poll(t, r);
        count++;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    now_ms        = '0;
    raw_levels    = '1;
    debounce_we   = 1'b0;
    debounce_time = DEBOUNCE_RESET;
    burst_left    = 4;
    settings      = 0;
    sent_raw      = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset debounce time
    send_poll(32'h0000_0000, 10'h3FF);
    send_poll(32'h0000_000A, 10'h3FE);
    send_poll(32'h0000_003C, 10'h3FE);  // exactly at the debounce time, no event
    send_poll(32'h0000_003D, 10'h3FE);
    send_poll(32'h0000_003D, 10'h000);
    send_poll(32'h0000_00C8, 10'h000);
    send_poll(32'h0000_012C, 10'h3FF);
    send_poll(32'h0000_015F, 10'h3FF);  // all ten buttons release at once
    send_poll(32'hFFFF_FFF0, 10'h2AA);
    send_poll(32'h0000_0030, 10'h2AA);  // across the time wrap
    send_poll(32'h0000_0030, 10'h3FF);  // change in the same poll, no event
    send_poll(32'hFFFF_FFFF, 10'h3FF);
    send_poll(32'hFFFF_FFFF, 10'h155);
    send_poll(32'h0000_0010, 10'h3FF);  // bounce back before it settles
    send_poll(32'h0000_0100, 10'h3FF);

    drain();
    write_hold('0);
    send_poll(32'h0000_0100, 10'h3FE);
    send_poll(32'h0000_0101, 10'h3FE);

    drain();
    write_hold('1);
    send_poll(32'h0000_0200, 10'h3FF);
    send_poll(32'h0001_01FF, 10'h3FF);
    send_poll(32'h0001_0200, 10'h3FF);

    run_phase(DEBOUNCE_RESET, PHASE_POLLS);
    run_phase('0, PHASE_POLLS);
    run_phase('1, PHASE_POLLS);
    run_phase(DEB_W'(1), PHASE_POLLS);
    run_phase(DEB_W'($urandom_range(2, 300)), PHASE_POLLS);
    run_phase(DEB_W'($urandom_range(0, 65535)), PHASE_POLLS);
    drain();

    $display("covered %0d polls, %0d button events, %0d debounce settings",
             tracker.polls, tracker.events, settings);
    $display("mismatches found: %0d", tracker.errors);
    if (tracker.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mbd_pkg.sv
hdl/mbd_lane.sv
hdl/mbd_merge.sv
hdl/multi_button_debouncer.sv
tb/tb_top.sv
